// ----- src/mftt_pkg.sv -----
package mftt_pkg;

    localparam int WINDOW    = 5;
    localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);

    localparam int ECHO_W    = 16;
    localparam int DIST_W    = 11;
    localparam int GAIN_W    = 6;
    localparam int OFFS_W    = 12;
    localparam int TONE_W    = 8;
    localparam int FREQ_W    = 16;
    localparam int CPROD_W   = ECHO_W + DIST_W;
    localparam int GPROD_W   = DIST_W + GAIN_W;

    localparam logic [DIST_W-1:0] CM_SCALE = 11'd1126;
    localparam int                CM_SHIFT = 16;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;
    localparam int OUT_DW    = 40;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_MAXD   = 2'd2;
    localparam logic [1:0] REG_TONE   = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_RST = 6'd10;
    localparam logic [OFFS_W-1:0] OFFS_RST = 12'd500;
    localparam logic [DIST_W-1:0] MAXD_RST = 11'd200;
    localparam logic [TONE_W-1:0] TONE_RST = 8'd50;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [OFFS_W-1:0] offset;
        logic [DIST_W-1:0] max_dist;
        logic [TONE_W-1:0] tone_ms;
    } t_cfg;

    typedef struct packed {
        logic load_echo;
        logic convert;
        logic rank_clear;
        logic rank_step;
        logic mul;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic rank_found;
        logic rank_last;
        logic reject;
        logic out_stall;
    } t_status;

endpackage

// ----- src/mftt_cfg_regs.sv -----
module mftt_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [mftt_pkg::APB_AW-1:0]  i_paddr,
    input  logic [mftt_pkg::APB_DW-1:0]  i_pwdata,
    output logic [mftt_pkg::APB_DW-1:0]  o_prdata,
    output logic                         o_pready,
    output mftt_pkg::t_cfg               o_cfg
);

    mftt_pkg::t_cfg r_cfg;
    logic [1:0]     w_idx;
    logic           w_wr;

    assign w_idx    = i_paddr[3:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain     <= mftt_pkg::GAIN_RST;
            r_cfg.offset   <= mftt_pkg::OFFS_RST;
            r_cfg.max_dist <= mftt_pkg::MAXD_RST;
            r_cfg.tone_ms  <= mftt_pkg::TONE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                mftt_pkg::REG_GAIN:   r_cfg.gain     <= i_pwdata[mftt_pkg::GAIN_W-1:0];
                mftt_pkg::REG_OFFSET: r_cfg.offset   <= i_pwdata[mftt_pkg::OFFS_W-1:0];
                mftt_pkg::REG_MAXD:   r_cfg.max_dist <= i_pwdata[mftt_pkg::DIST_W-1:0];
                mftt_pkg::REG_TONE:   r_cfg.tone_ms  <= i_pwdata[mftt_pkg::TONE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mftt_pkg::REG_GAIN:   o_prdata = mftt_pkg::APB_DW'(r_cfg.gain);
            mftt_pkg::REG_OFFSET: o_prdata = mftt_pkg::APB_DW'(r_cfg.offset);
            mftt_pkg::REG_MAXD:   o_prdata = mftt_pkg::APB_DW'(r_cfg.max_dist);
            mftt_pkg::REG_TONE:   o_prdata = mftt_pkg::APB_DW'(r_cfg.tone_ms);
            default:              o_prdata = '0;
        endcase
    end

endmodule

// ----- src/mftt_datapath.sv -----
module mftt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mftt_pkg::t_cfg                i_cfg,
    input  mftt_pkg::t_cmd                i_cmd,
    output mftt_pkg::t_status             o_status,
    input  logic [mftt_pkg::ECHO_W-1:0]   i_echo,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mftt_pkg::OUT_DW-1:0]   o_m_tdata
);

    logic [mftt_pkg::ECHO_W-1:0]  r_echo;
    logic [mftt_pkg::DIST_W-1:0]  r_win [mftt_pkg::WINDOW];
    logic [mftt_pkg::IDX_W-1:0]   r_idx;
    logic [mftt_pkg::DIST_W-1:0]  r_med;
    logic [mftt_pkg::DIST_W-1:0]  r_last;
    logic [mftt_pkg::GPROD_W-1:0] r_gprod;
    logic                         r_out_valid;
    logic [mftt_pkg::FREQ_W-1:0]  r_out_freq;
    logic [mftt_pkg::TONE_W-1:0]  r_out_ms;
    logic [mftt_pkg::DIST_W-1:0]  r_out_med;

    logic [mftt_pkg::CPROD_W-1:0] w_cprod;
    logic [mftt_pkg::DIST_W-1:0]  w_dist;
    logic [mftt_pkg::DIST_W-1:0]  w_cand;
    logic [mftt_pkg::WINDOW-1:0]  w_below;
    logic [mftt_pkg::CNT_W-1:0]   w_rank;
    logic                         w_found;
    logic [mftt_pkg::GPROD_W+1:0] w_sum;
    logic [mftt_pkg::FREQ_W-1:0]  w_freq;

    assign w_cprod = mftt_pkg::CPROD_W'(r_echo) * mftt_pkg::CPROD_W'(mftt_pkg::CM_SCALE);
    assign w_dist  = w_cprod[mftt_pkg::CPROD_W-1:mftt_pkg::CM_SHIFT];
    assign w_cand  = r_win[r_idx];

    // rank of the candidate, ties broken by position so exactly one entry
    // lands on the middle rank
    always_comb begin
        for (int j = 0; j < mftt_pkg::WINDOW; j++) begin
            w_below[j] = (r_win[j] < w_cand) ||
                         ((r_win[j] == w_cand) && (mftt_pkg::IDX_W'(j) < r_idx));
        end
        w_rank  = mftt_pkg::CNT_W'($countones(w_below));
        w_found = (w_rank == mftt_pkg::CNT_W'(mftt_pkg::WINDOW / 2));
    end

    assign w_sum  = (mftt_pkg::GPROD_W+2)'(r_gprod) + (mftt_pkg::GPROD_W+2)'(i_cfg.offset);
    assign w_freq = (w_sum[mftt_pkg::GPROD_W+1:mftt_pkg::FREQ_W] != '0) ?
                    '1 : w_sum[mftt_pkg::FREQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mftt_pkg::WINDOW; k++) begin
                r_win[k] <= '0;
            end
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.convert) begin
                for (int k = 0; k < mftt_pkg::WINDOW - 1; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[mftt_pkg::WINDOW-1] <= w_dist;
            end
            if (i_cmd.rank_clear) begin
                r_idx <= '0;
            end else if (i_cmd.rank_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_last      <= r_med;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_echo) begin
            r_echo <= i_echo;
        end
        if (i_cmd.rank_step && w_found) begin
            r_med <= w_cand;
        end
        if (i_cmd.mul) begin
            r_gprod <= mftt_pkg::GPROD_W'(r_med) * mftt_pkg::GPROD_W'(i_cfg.gain);
        end
        if (i_cmd.emit) begin
            r_out_freq <= w_freq;
            r_out_ms   <= i_cfg.tone_ms;
            r_out_med  <= r_med;
        end
    end

    assign o_status.rank_found = w_found;
    assign o_status.rank_last  = (r_idx == mftt_pkg::IDX_W'(mftt_pkg::WINDOW - 1));
    assign o_status.reject     = (r_med == r_last) || (r_med > i_cfg.max_dist);
    assign o_status.out_stall  = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_med, r_out_ms, r_out_freq};

endmodule

// ----- src/mftt_ctrl.sv -----
module mftt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  mftt_pkg::t_status  i_status,
    output mftt_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_RANK  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_echo = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.convert    = 1'b1;
                o_cmd.rank_clear = 1'b1;
                n_state          = S_RANK;
            end
            S_RANK: begin
                o_cmd.rank_step = 1'b1;
                if (i_status.rank_found || i_status.rank_last) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_status.reject ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // hold until the previous request has left the output register
                if (!i_status.out_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_median_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK && i_status.rank_last) |-> i_status.rank_found)
        else $error("no window entry reached the middle rank");
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> !i_status.out_stall)
        else $error("result loaded over a pending output");
    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CONV))
        else $error("accepted request did not start conversion");
    a_pass_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !i_status.reject) |=> (r_state == S_MUL))
        else $error("accepted median did not reach the multiplier");
`endif

endmodule

// ----- src/median_filtered_range_to_tone_unit.sv -----
// Median-filtered range to tone. Each echo time request (microseconds) is
// converted to centimetres as (echo * 1126) >> 16, shifted into a window of the
// last five distances (all zero after reset), and the median of that window is
// taken. When the median differs from the last emitted distance and is at most
// max_distance, one result leaves with tone_freq = median * freq_gain +
// freq_offset (saturated at 65535), tone_ms and the median; otherwise the
// request produces nothing. A conversion step converts the echo and shifts the
// window, the rank search steps through one window entry per cycle until it
// finds the middle rank, a check step tests the median, and the gain multiply
// and the output load follow as separate steps. A request is taken only in the
// idle state, so the next one waits until the last has been checked and, if it
// passes, loaded. A finished result sits in an output register, so the next
// request is taken while it waits; a new result stalls only if the previous one
// has not yet been taken.
module median_filtered_range_to_tone_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [15:0] echo_time
    input  logic [mftt_pkg::ECHO_W-1:0]   i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [15:0] tone_freq, [23:16] tone_ms, [34:24] median_distance, [39:35] zero
    output logic [mftt_pkg::OUT_DW-1:0]   o_m_tdata,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [mftt_pkg::APB_AW-1:0]   i_paddr,
    input  logic [mftt_pkg::APB_DW-1:0]   i_pwdata,
    output logic [mftt_pkg::APB_DW-1:0]   o_prdata,
    output logic                          o_pready
);

    mftt_pkg::t_cfg    w_cfg;
    mftt_pkg::t_cmd    w_cmd;
    mftt_pkg::t_status w_status;

    mftt_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    mftt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mftt_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_echo     (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
